>>> rtl/fsv_pkg.sv
// Package of the FASTA stream validator: item and state types, status codes
// and the byte codes that the line parser looks for. No dependencies.
package fsv_pkg;

  typedef enum logic [2:0] {
    StRunning    = 3'd0,
    StDoneOk     = 3'd1,
    StNul        = 3'd2,
    StEmptySeq   = 3'd3,
    StEmptyHdr   = 3'd4,
    StDataFirst  = 3'd5,
    StNoSeqs     = 3'd6,
    StLastEmpty  = 3'd7
  } fsv_status_e;

  localparam logic [7:0] ByteHeader = 8'h3E;
  localparam logic [7:0] ByteLf     = 8'h0A;
  localparam logic [7:0] ByteCr     = 8'h0D;
  localparam logic [7:0] ByteNul    = 8'h00;
  localparam logic [7:0] ByteSpace  = 8'h20;
  localparam logic [7:0] ByteTab    = 8'h09;
  localparam logic [7:0] ByteVtab   = 8'h0B;
  localparam logic [7:0] ByteFf     = 8'h0C;

  localparam int unsigned OutCountBits = 32;
  localparam int unsigned TdataBits    = 112;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_file;
  } fsv_item_t;

  typedef struct packed {
    logic at_line_start;
    logic line_is_header;
    logic line_cut;
    logic line_has_text;
    logic line_has_nul;
    logic in_record;
    logic record_has_data;
  } fsv_flags_t;

  localparam fsv_flags_t FlagsReset = '{
    at_line_start:   1'b1,
    line_is_header:  1'b0,
    line_cut:        1'b0,
    line_has_text:   1'b0,
    line_has_nul:    1'b0,
    in_record:       1'b0,
    record_has_data: 1'b0
  };

endpackage

>>> rtl/fsv_in_stage.sv
// Input register of the FASTA stream validator with its stream handshake.
// Depends on fsv_pkg for the item type.
module fsv_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fsv_pkg::fsv_item_t in_item_i,
  output logic              item_valid_o,
  output fsv_pkg::fsv_item_t item_o,
  input  logic              item_take_i
);

  logic               valid_q;
  logic               valid_d;
  fsv_pkg::fsv_item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/fsv_step.sv
// Per-item line parser of the FASTA stream validator: next state, counters,
// status and the result fields for one item. Depends on fsv_pkg.
module fsv_step #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  fsv_pkg::fsv_item_t   item_i,
  input  logic                 skip_empty_headers_i,
  input  fsv_pkg::fsv_flags_t  flags_i,
  input  fsv_pkg::fsv_status_e status_i,
  input  logic [COUNT_BITS-1:0] line_cnt_i,
  input  logic [COUNT_BITS-1:0] rec_cnt_i,
  input  logic [COUNT_BITS-1:0] res_cnt_i,
  output fsv_pkg::fsv_flags_t  flags_o,
  output fsv_pkg::fsv_status_e status_o,
  output logic [COUNT_BITS-1:0] line_cnt_o,
  output logic [COUNT_BITS-1:0] rec_cnt_o,
  output logic [COUNT_BITS-1:0] res_cnt_o,
  output logic                 residue_valid_o,
  output logic [7:0]           residue_o,
  output logic                 record_start_o
);

  logic [COUNT_BITS-1:0] line_inc;
  logic [COUNT_BITS-1:0] rec_inc;
  logic [COUNT_BITS-1:0] res_inc;

  assign line_inc = (&line_cnt_i) ? line_cnt_i : line_cnt_i + 1'b1;
  assign rec_inc  = (&rec_cnt_i)  ? rec_cnt_i  : rec_cnt_i + 1'b1;
  assign res_inc  = (&res_cnt_i)  ? res_cnt_i  : res_cnt_i + 1'b1;

  always_comb begin
    fsv_pkg::fsv_flags_t  f;
    fsv_pkg::fsv_status_e st;
    logic                 first;
    logic                 blank;
    logic                 run;
    logic                 finish;
    logic [7:0]           b;

    f     = flags_i;
    st    = status_i;
    b     = item_i.data_byte;
    run   = (status_i == fsv_pkg::StRunning);
    first = f.at_line_start;
    blank = b inside {fsv_pkg::ByteSpace, fsv_pkg::ByteTab, fsv_pkg::ByteVtab,
                      fsv_pkg::ByteFf};
    line_cnt_o      = line_cnt_i;
    rec_cnt_o       = rec_cnt_i;
    res_cnt_o       = res_cnt_i;
    residue_valid_o = 1'b0;
    residue_o       = '0;
    record_start_o  = 1'b0;

    if (run && item_i.has_byte) begin
      if (first) begin
        f.at_line_start  = 1'b0;
        line_cnt_o       = line_inc;
        f.line_is_header = (b == fsv_pkg::ByteHeader);
        f.line_cut       = 1'b0;
        f.line_has_text  = 1'b0;
        f.line_has_nul   = 1'b0;
        if (f.line_is_header) begin
          record_start_o = 1'b1;
          res_cnt_o      = '0;
        end
      end
      if (b != fsv_pkg::ByteLf) begin
        if (b == fsv_pkg::ByteNul) begin
          f.line_has_nul = 1'b1;
        end
        if (!f.line_cut) begin
          if (b == fsv_pkg::ByteCr) begin
            f.line_cut = 1'b1;
          end else if (!blank && !(first && f.line_is_header)) begin
            f.line_has_text = 1'b1;
            if (!f.line_is_header && f.in_record) begin
              residue_valid_o = 1'b1;
              residue_o       = b;
              res_cnt_o       = res_inc;
            end
          end
        end
      end
    end

    // A newline closes the line; so does the end of the file on an open line.
    finish = run && ((item_i.has_byte && (b == fsv_pkg::ByteLf)) ||
                     (item_i.end_of_file && !f.at_line_start));
    if (finish) begin
      f.at_line_start = 1'b1;
      if (f.line_has_nul) begin
        st = fsv_pkg::StNul;
      end else if (f.line_is_header) begin
        if (f.in_record && !f.record_has_data) begin
          st = fsv_pkg::StEmptySeq;
        end else if (!f.line_has_text && !skip_empty_headers_i) begin
          st = fsv_pkg::StEmptyHdr;
        end else begin
          rec_cnt_o         = rec_inc;
          f.in_record       = 1'b1;
          f.record_has_data = 1'b0;
        end
      end else if (f.line_has_text) begin
        if (f.in_record) begin
          f.record_has_data = 1'b1;
        end else begin
          st = fsv_pkg::StDataFirst;
        end
      end
    end

    if (run && item_i.end_of_file && (st == fsv_pkg::StRunning)) begin
      if (!f.in_record) begin
        st = fsv_pkg::StNoSeqs;
      end else if (!f.record_has_data) begin
        st = fsv_pkg::StLastEmpty;
      end else begin
        st = fsv_pkg::StDoneOk;
      end
    end

    flags_o  = f;
    status_o = st;
  end

endmodule

>>> rtl/fasta_stream_validator_core.sv
// Top level of the FASTA stream validator: input stage, parser state,
// result register and configuration port. Depends on fsv_pkg, fsv_in_stage, fsv_step.
//
// The slave stream carries one file byte per item (tuser is has_byte, tlast
// marks the item that ends the file). Every accepted item gives exactly one
// result item on the master stream, with the residue flag, the record start
// flag, the status and the line, record and residue counters after that item.
// An accepted item sits in the input register, and its result is loaded into
// the result register once that register is free or its item is being taken.
// The parser state is a set of flags and three counters that update from each
// taken item, so one item is taken in every cycle while the result side keeps up.
// When the receiver stalls, the result register holds its item, the input
// register fills, and s_axis_tready_o drops until the result is taken.
// Reset clears the valid bits of both registers, the parser state and the
// skip_empty_headers register. Once a final status is reported, further items
// still each give a result, with the counters and status held, until the next
// reset. skip_empty_headers lies at byte address 0 of the APB port; the user
// must write it only while no item is in flight: the block does not enforce it.
module fasta_stream_validator_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] has_byte
  input  logic         s_axis_tlast_i,   // end_of_file
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] residue, [10:8] status, [42:11] line_count,
  // [74:43] sequence_count, [106:75] residue_count, [111:107] zero
  output logic [fsv_pkg::TdataBits-1:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,   // [0] residue_valid, [1] record_start
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic                 skip_q;
  logic                 item_valid;
  logic                 take;
  fsv_pkg::fsv_item_t   in_item;
  fsv_pkg::fsv_item_t   item;
  fsv_pkg::fsv_flags_t  flags_q;
  fsv_pkg::fsv_flags_t  flags_d;
  fsv_pkg::fsv_status_e status_q;
  fsv_pkg::fsv_status_e status_d;
  logic [COUNT_BITS-1:0] line_cnt_q;
  logic [COUNT_BITS-1:0] line_cnt_d;
  logic [COUNT_BITS-1:0] rec_cnt_q;
  logic [COUNT_BITS-1:0] rec_cnt_d;
  logic [COUNT_BITS-1:0] res_cnt_q;
  logic [COUNT_BITS-1:0] res_cnt_d;
  logic                 res_valid;
  logic [7:0]           res_byte;
  logic                 rec_start;
  logic [COUNT_BITS+31:0] line_ext;
  logic [COUNT_BITS+31:0] rec_ext;
  logic [COUNT_BITS+31:0] res_ext;
  logic                 out_valid_q;
  logic [fsv_pkg::TdataBits-1:0] out_data_q;
  logic [fsv_pkg::TdataBits-1:0] out_data_d;
  logic [1:0]           out_user_q;

  assign pready = 1'b1;
  assign prdata = {31'b0, skip_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      skip_q <= pwdata[0];
    end
  end

  assign in_item = '{data_byte: s_axis_tdata_i, has_byte: s_axis_tuser_i,
                     end_of_file: s_axis_tlast_i};

  fsv_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (take)
  );

  assign take = item_valid && (!out_valid_q || m_axis_tready_i);

  fsv_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .item_i               (item),
    .skip_empty_headers_i (skip_q),
    .flags_i              (flags_q),
    .status_i             (status_q),
    .line_cnt_i           (line_cnt_q),
    .rec_cnt_i            (rec_cnt_q),
    .res_cnt_i            (res_cnt_q),
    .flags_o              (flags_d),
    .status_o             (status_d),
    .line_cnt_o           (line_cnt_d),
    .rec_cnt_o            (rec_cnt_d),
    .res_cnt_o            (res_cnt_d),
    .residue_valid_o      (res_valid),
    .residue_o            (res_byte),
    .record_start_o       (rec_start)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= fsv_pkg::FlagsReset;
      status_q   <= fsv_pkg::StRunning;
      line_cnt_q <= '0;
      rec_cnt_q  <= '0;
      res_cnt_q  <= '0;
    end else if (take) begin
      flags_q    <= flags_d;
      status_q   <= status_d;
      line_cnt_q <= line_cnt_d;
      rec_cnt_q  <= rec_cnt_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  assign line_ext = {32'b0, line_cnt_d};
  assign rec_ext  = {32'b0, rec_cnt_d};
  assign res_ext  = {32'b0, res_cnt_d};

  assign out_data_d = {5'b0,
                       res_ext[fsv_pkg::OutCountBits-1:0],
                       rec_ext[fsv_pkg::OutCountBits-1:0],
                       line_ext[fsv_pkg::OutCountBits-1:0],
                       status_d,
                       res_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= out_data_d;
      out_user_q <= {rec_start, res_valid};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

>>> rtl/fsv_checker.sv
// Port-level checks of the FASTA stream validator and their bind to the top
// level. Depends on fasta_stream_validator_core.
module fsv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [111:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  a_reset_no_result: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("residue on a header start");

  a_start_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o[106:75] == 32'd0)
    else $error("residue count not cleared at record start");

  a_residue_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("residue byte set without residue flag");

endmodule

bind fasta_stream_validator_core fsv_checker u_fsv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> tb/fasta_stream_validator_core_tb.sv
// Testbench for fasta_stream_validator_core: drives FASTA bytes on the slave stream and
// checks every result item against a cycle-free parser written here or a typed script row.
// Depends on fsv_pkg and fasta_stream_validator_core.
`timescale 1ns / 1ps

module fasta_stream_validator_core_tb;

  localparam int unsigned CountBits = 32;
  localparam logic [1:0] SkipRegAddr = 2'd0;
  localparam int NumScriptRows = 21;
  localparam int NumPhases = 4;
  localparam int LiveItemsPerPhase = 330;

  typedef struct packed {
    logic                 rvalid;
    logic [7:0]           rbyte;
    logic                 rstart;
    fsv_pkg::fsv_status_e status;
    logic [31:0]          line_no;
    logic [31:0]          seq_cnt;
    logic [31:0]          res_cnt;
  } parse_out_t;

  typedef struct packed {
    fsv_pkg::fsv_item_t item;
    logic               typed;
    parse_out_t         want;
  } script_row_t;

  typedef enum int {OpenNormal, OpenDataFirst, OpenNoSeqs} file_open_e;
  typedef enum int {
    EndClean, EndOpenLine, EndNul, EndEmptySeq, EndEmptyHdr, EndLastEmpty
  } file_end_e;

  // Header with no text (accepted), a residue line with whitespace and a
  // carriage-return cut, a blank line, a header with text, a residue line, idle items.
  localparam script_row_t OpeningScript [NumScriptRows] = '{
    '{'{8'hA5, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 8'h00, 1'b0, fsv_pkg::StRunning, 32'd0, 32'd0, 32'd0}},
    '{'{fsv_pkg::ByteHeader, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 8'h00, 1'b1, fsv_pkg::StRunning, 32'd1, 32'd0, 32'd0}},
    '{'{fsv_pkg::ByteLf, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 8'h00, 1'b0, fsv_pkg::StRunning, 32'd1, 32'd1, 32'd0}},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b1,
      '{1'b1, 8'hFF, 1'b0, fsv_pkg::StRunning, 32'd2, 32'd1, 32'd1}},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteSpace, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteTab, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteVtab, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteFf, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteCr, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h58, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteLf, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteSpace, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteLf, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteHeader, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 8'h00, 1'b1, fsv_pkg::StRunning, 32'd4, 32'd1, 32'd0}},
    '{'{8'h68, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteLf, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h7E, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h5A, 1'b0, 1'b0}, 1'b0, '0},
    '{'{fsv_pkg::ByteLf, 1'b1, 1'b0}, 1'b0, '0}
  };

  logic         clk = 1'b0;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [1:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  fsv_pkg::fsv_flags_t  line_flags;
  fsv_pkg::fsv_status_e file_status;
  logic [CountBits-1:0] lines_seen;
  logic [CountBits-1:0] records_seen;
  logic [CountBits-1:0] residues_seen;
  logic                 skip_cfg;

  parse_out_t outs_due[$];
  int         mismatches = 0;
  int         live_items = 0;
  int         fed = 0;
  bit         in_busy;

  fasta_stream_validator_core #(.COUNT_BITS(CountBits)) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == fsv_pkg::ByteSpace || b == fsv_pkg::ByteTab ||
           b == fsv_pkg::ByteVtab || b == fsv_pkg::ByteFf;
  endfunction

  function automatic void close_line();
    line_flags.at_line_start = 1'b1;
    if (line_flags.line_has_nul) begin
      file_status = fsv_pkg::StNul;
    end else if (line_flags.line_is_header) begin
      if (line_flags.in_record && !line_flags.record_has_data) begin
        file_status = fsv_pkg::StEmptySeq;
      end else if (!line_flags.line_has_text && !skip_cfg) begin
        file_status = fsv_pkg::StEmptyHdr;
      end else begin
        records_seen = bump(records_seen);
        line_flags.in_record = 1'b1;
        line_flags.record_has_data = 1'b0;
      end
    end else if (line_flags.line_has_text) begin
      if (line_flags.in_record) begin
        line_flags.record_has_data = 1'b1;
      end else begin
        file_status = fsv_pkg::StDataFirst;
      end
    end
  endfunction

  function automatic void parse_step(input fsv_pkg::fsv_item_t it, output parse_out_t r);
    logic first;
    r = '0;
    if (file_status == fsv_pkg::StRunning && it.has_byte) begin
      first = line_flags.at_line_start;
      if (first) begin
        line_flags.at_line_start = 1'b0;
        lines_seen = bump(lines_seen);
        line_flags.line_is_header = (it.data_byte == fsv_pkg::ByteHeader);
        line_flags.line_cut = 1'b0;
        line_flags.line_has_text = 1'b0;
        line_flags.line_has_nul = 1'b0;
        if (line_flags.line_is_header) begin
          r.rstart = 1'b1;
          residues_seen = '0;
        end
      end
      if (it.data_byte == fsv_pkg::ByteLf) begin
        close_line();
      end else begin
        if (it.data_byte == fsv_pkg::ByteNul) line_flags.line_has_nul = 1'b1;
        if (!line_flags.line_cut) begin
          if (it.data_byte == fsv_pkg::ByteCr) begin
            line_flags.line_cut = 1'b1;
          end else if (!is_ws(it.data_byte) &&
                       !(first && line_flags.line_is_header)) begin
            line_flags.line_has_text = 1'b1;
            if (!line_flags.line_is_header && line_flags.in_record) begin
              r.rvalid = 1'b1;
              r.rbyte = it.data_byte;
              residues_seen = bump(residues_seen);
            end
          end
        end
      end
    end
    if (file_status == fsv_pkg::StRunning && it.end_of_file) begin
      if (!line_flags.at_line_start) close_line();
      if (file_status == fsv_pkg::StRunning) begin
        if (!line_flags.in_record) begin
          file_status = fsv_pkg::StNoSeqs;
        end else if (!line_flags.record_has_data) begin
          file_status = fsv_pkg::StLastEmpty;
        end else begin
          file_status = fsv_pkg::StDoneOk;
        end
      end
    end
    r.status = file_status;
    r.line_no = lines_seen[fsv_pkg::OutCountBits-1:0];
    r.seq_cnt = records_seen[fsv_pkg::OutCountBits-1:0];
    r.res_cnt = residues_seen[fsv_pkg::OutCountBits-1:0];
  endfunction

  function automatic logic [7:0] letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  // Any byte but newline and NUL, weighted toward residue letters.
  function automatic logic [7:0] content_byte();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 15);
    if (pick < 10) begin
      b = letter();
    end else if (pick == 10) begin
      case ($urandom_range(0, 3))
        0: b = fsv_pkg::ByteSpace;
        1: b = fsv_pkg::ByteTab;
        2: b = fsv_pkg::ByteVtab;
        default: b = fsv_pkg::ByteFf;
      endcase
    end else if (pick == 11) begin
      b = fsv_pkg::ByteCr;
    end else begin
      b = 8'($urandom_range(1, 255));
      if (b == fsv_pkg::ByteLf) b = 8'hFF;
    end
    return b;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic feed(input fsv_pkg::fsv_item_t it, input logic typed, input parse_out_t want);
    parse_out_t predicted;
    int gap;
    parse_step(it, predicted);
    outs_due.push_back(typed ? want : predicted);
    if (fed % 40 == 0) in_busy = ($urandom_range(0, 2) != 0);
    fed++;
    gap = in_busy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = it.data_byte;
    s_tuser = it.has_byte;
    s_tlast = it.end_of_file;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send(input logic [7:0] b, input logic has, input logic eof);
    fsv_pkg::fsv_item_t it;
    it.data_byte = b;
    it.has_byte = has;
    it.end_of_file = eof;
    if (has) live_items++;
    feed(it, 1'b0, '0);
  endtask

  task automatic put_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) send(8'($urandom), 1'b0, 1'b0);
    send(b, 1'b1, 1'b0);
  endtask

  task automatic put_tail();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      put_byte(fsv_pkg::ByteCr);
      n = $urandom_range(0, 4);
      repeat (n) put_byte(content_byte());
    end
    put_byte(fsv_pkg::ByteLf);
  endtask

  task automatic put_header(input logic need_text);
    int n;
    logic [7:0] b;
    put_byte(fsv_pkg::ByteHeader);
    n = need_text ? $urandom_range(1, 6) : $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      b = content_byte();
      if (i == 0 && need_text) b = letter();
      put_byte(b);
    end
    put_tail();
  endtask

  task automatic put_seq_line(input logic need_data);
    int n;
    logic [7:0] b;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      b = content_byte();
      if (i == 0 && (need_data || b == fsv_pkg::ByteHeader)) b = letter();
      put_byte(b);
    end
    put_tail();
  endtask

  task automatic put_blank_line();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) put_byte(fsv_pkg::ByteSpace);
    put_tail();
  endtask

  task automatic put_record();
    int n;
    put_header(!skip_cfg);
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) put_blank_line();
      put_seq_line(i == 0);
    end
  endtask

  task automatic drain();
    while (outs_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_skip_reg(input logic v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = SkipRegAddr;
    pwdata = {31'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    skip_cfg = v;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    cmp_field("skip_empty_headers readback", prdata, {31'd0, v});
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  initial begin : result_sink
    parse_out_t got;
    parse_out_t want;
    int gap;
    int taken;
    bit out_busy;
    taken = 0;
    out_busy = 1'b0;
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken % 48 == 0) out_busy = ($urandom_range(0, 2) != 0);
      gap = out_busy ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      got.rvalid = m_tuser[0];
      got.rstart = m_tuser[1];
      got.rbyte = m_tdata[7:0];
      got.status = fsv_pkg::fsv_status_e'(m_tdata[10:8]);
      got.line_no = m_tdata[42:11];
      got.seq_cnt = m_tdata[74:43];
      got.res_cnt = m_tdata[106:75];
      if (outs_due.size() == 0) begin
        flag_mismatch("result item with none pending");
      end else begin
        want = outs_due.pop_front();
        cmp_field("residue_valid", 32'(got.rvalid), 32'(want.rvalid));
        cmp_field("residue", 32'(got.rbyte), 32'(want.rbyte));
        cmp_field("record_start", 32'(got.rstart), 32'(want.rstart));
        cmp_field("status", 32'(got.status), 32'(want.status));
        cmp_field("line_count", got.line_no, want.line_no);
        cmp_field("sequence_count", got.seq_cnt, want.seq_cnt);
        cmp_field("residue_count", got.res_cnt, want.res_cnt);
      end
    end
  end

  initial begin : stimulus
    file_open_e opening;
    file_end_e ending;
    int pick;
    int n;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = SkipRegAddr;
    pwdata = 32'd0;
    line_flags = fsv_pkg::FlagsReset;
    file_status = fsv_pkg::StRunning;
    lines_seen = '0;
    records_seen = '0;
    residues_seen = '0;
    skip_cfg = 1'b0;
    in_busy = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pick = $urandom_range(0, 9);
    opening = (pick == 0) ? OpenDataFirst : (pick == 1) ? OpenNoSeqs : OpenNormal;
    write_skip_reg(1'b1);
    case (opening)
      OpenDataFirst: begin
        put_byte(letter());
        put_byte(fsv_pkg::ByteSpace);
        put_byte(letter());
        put_byte(fsv_pkg::ByteLf);
      end
      OpenNoSeqs: begin
        if ($urandom_range(0, 1)) put_blank_line();
        send(fsv_pkg::ByteSpace, 1'($urandom_range(0, 1)), 1'b1);
      end
      default: begin
        for (int i = 0; i < NumScriptRows; i++) begin
          feed(OpeningScript[i].item, OpeningScript[i].typed, OpeningScript[i].want);
        end
      end
    endcase

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      write_skip_reg(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      while (live_items < (phase + 1) * LiveItemsPerPhase) put_record();
    end
    ending = file_end_e'($urandom_range(0, 5));
    drain();
    write_skip_reg(ending == EndEmptyHdr ? 1'b0 : 1'($urandom_range(0, 1)));
    case (ending)
      EndClean: send(8'($urandom), 1'b0, 1'b1);
      EndOpenLine: begin
        n = $urandom_range(0, 5);
        repeat (n) put_byte(letter());
        send(letter(), 1'b1, 1'b1);
      end
      EndNul: begin
        n = $urandom_range(0, 3);
        repeat (n) put_byte(letter());
        if ($urandom_range(0, 1)) put_byte(fsv_pkg::ByteCr);
        put_byte(fsv_pkg::ByteNul);
        put_byte(letter());
        put_byte(fsv_pkg::ByteLf);
      end
      EndEmptySeq: begin
        put_header(1'b1);
        put_header(1'b1);
      end
      EndEmptyHdr: begin
        put_byte(fsv_pkg::ByteHeader);
        n = $urandom_range(0, 2);
        repeat (n) put_byte(fsv_pkg::ByteTab);
        if ($urandom_range(0, 1)) send(fsv_pkg::ByteLf, 1'b1, 1'b0);
        else send(fsv_pkg::ByteSpace, 1'b1, 1'b1);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          put_header(1'b1);
          send(8'($urandom), 1'b0, 1'b1);
        end else begin
          put_byte(fsv_pkg::ByteHeader);
          send(letter(), 1'b1, 1'b1);
        end
      end
    endcase

    // The file is closed now: everything that follows must be ignored.
    repeat (16) send(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("fasta_stream_validator_core regression: pass");
    end else begin
      $display("fasta_stream_validator_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("fasta_stream_validator_core regression: fail");
    $finish;
  end

endmodule
